>>> hdl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg: shared types and constants of the pattern pixel generator
// Register map, pattern select codes, fixed field widths and the
// constants behind the cosine table and the border math.
// ----------------------------------------------------------------------------
package slpg_pkg;

    // Fixed field widths of the register file and the result.
    localparam int MODE_BITS   = 3;
    localparam int STEP_BITS   = 24;
    localparam int FRAME_BITS  = 13;
    localparam int PERIOD_BITS = 12;
    localparam int PIX_BITS    = 8;
    localparam int BORDER_BITS = 9;

    // Pattern select codes.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_VFRINGE = 3'd0,
        MODE_HFRINGE = 3'd1,
        MODE_CHECKER = 3'd2,
        MODE_BLACK   = 3'd3,
        MODE_BORDER  = 3'd4
    } t_mode;

    // Register indexes (byte address = 4 * index).
    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_PHASE_STEP   = 3'd1,
        REG_PHASE_OFFSET = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4,
        REG_COL_PERIOD   = 3'd5,
        REG_ROW_PERIOD   = 3'd6
    } t_reg_idx;

    // Register reset values.
    localparam logic [FRAME_BITS-1:0]  FRAME_WIDTH_RST  = 13'd1024;
    localparam logic [FRAME_BITS-1:0]  FRAME_HEIGHT_RST = 13'd768;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RST       = 12'd64;

    // Gray levels.
    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_BITS-1:0] PIX_MID = 8'd127;
    localparam logic [PIX_BITS-1:0] PIX_MIN = 8'd0;

    // Frame size / 25 as (size * 5243) >> 17, exact for all 13-bit sizes.
    localparam int                     DIV25_PROD_BITS = 2 * FRAME_BITS;
    localparam logic [FRAME_BITS-1:0]  DIV25_MUL       = 13'd5243;
    localparam int                     DIV25_SHIFT     = 17;

    // Cosine table scaling: level = floor(127.5 * (1 + cos)).
    localparam real COS_HALF_SCALE = 127.5;
    localparam real TWO_PI         = 6.283185307179586;

endpackage

>>> hdl/slpg_cos_rom.sv
// ----------------------------------------------------------------------------
// slpg_cos_rom: raised cosine lookup with registered read
// Full-turn table of floor(127.5 * (1 + cos(2*pi*t/N))), N = 2^INDEX_BITS,
// built at elaboration; exact levels at the quarter-turn points.
// ----------------------------------------------------------------------------
module slpg_cos_rom #(
    parameter int INDEX_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [INDEX_BITS-1:0]         i_index,
    output logic [slpg_pkg::PIX_BITS-1:0] o_value
);

    localparam int  DEPTH    = 1 << INDEX_BITS;
    localparam int  QUARTER  = DEPTH / 4;
    localparam real ANG_STEP = slpg_pkg::TWO_PI / real'(DEPTH);

    typedef logic [slpg_pkg::PIX_BITS-1:0] t_table [DEPTH];

    function automatic t_table f_build();
        t_table tbl;
        real    ang;
        real    lvl;
        int     lvl_int;
        int     quad;
        for (int i = 0; i < DEPTH; i++) begin
            ang     = ANG_STEP * real'(i);
            lvl     = $floor(slpg_pkg::COS_HALF_SCALE * (1.0 + $cos(ang)));
            lvl_int = $rtoi(lvl);
            if (lvl_int < 0) begin
                lvl_int = 0;
            end
            if (lvl_int > 255) begin
                lvl_int = 255;
            end
            tbl[i] = slpg_pkg::PIX_BITS'(lvl_int);
            // quarter-turn points: cos is exactly +1, 0, -1, 0
            if ((i & (QUARTER - 1)) == 0) begin
                quad = i >> (INDEX_BITS - 2);
                if (quad == 0) begin
                    tbl[i] = slpg_pkg::PIX_MAX;
                end else if (quad == 2) begin
                    tbl[i] = slpg_pkg::PIX_MIN;
                end else begin
                    tbl[i] = slpg_pkg::PIX_MID;
                end
            end
        end
        return tbl;
    endfunction

    localparam t_table COS_TABLE = f_build();

    logic [slpg_pkg::PIX_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= COS_TABLE[i_index];
        end
    end

    assign o_value = r_value;

endmodule

>>> hdl/structured_light_pattern_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// structured_light_pattern_pixel_generator_core: projector pattern pixel source
// Returns the 8-bit gray level of the selected structured-light pattern
// (vertical or horizontal cosine fringe, checkerboard, black, bordered white)
// for each pixel coordinate beat.
// ----------------------------------------------------------------------------
// Usage:
//   - Input channel (i_in_valid / o_in_ready) carries one pixel coordinate
//     (i_pixel_x, i_pixel_y) per beat; the output channel
//     (o_out_valid / i_out_ready) returns one o_pixel_value per input beat,
//     in order.
//   - A beat loads stage 1 at the accepting edge and moves on to stage 4,
//     where o_out_valid rises. Throughput is one beat per cycle unless the
//     output stalls: four register stages (phase multiply, phase add,
//     cosine table read, pattern select) each take a new beat every cycle.
//     The checker divider runs alongside in the first three stages,
//     ceil(COORD_BITS/3) restoring steps per stage.
//   - Program the registers through the APB port (register i at byte 4*i)
//     only while the pipeline is empty; writes complete with no wait states.
//   - Reset clears every stage valid bit and loads the register defaults
//     (vertical fringe, zero phase, 1024x768 frame, 64-pixel checker).
//   - When the receiver stalls, the output beat holds and upstream stages
//     keep filling until each holds a beat; bubbles collapse, so o_in_ready
//     drops only once all four stages are full.
//   - Coordinates outside the frame are computed by the same formulas.
// ----------------------------------------------------------------------------
module structured_light_pattern_pixel_generator_core #(
    parameter int COORD_BITS      = 12,
    parameter int PHASE_FRAC_BITS = 24,
    parameter int COS_INDEX_BITS  = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel coordinate channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [COORD_BITS-1:0]         i_pixel_x,
    input  logic [COORD_BITS-1:0]         i_pixel_y,
    // pixel value channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [slpg_pkg::PIX_BITS-1:0] o_pixel_value,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Phase step/offset registers keep at most the 24 written bits.
    localparam int STEP_W    = (PHASE_FRAC_BITS < slpg_pkg::STEP_BITS)
                               ? PHASE_FRAC_BITS : slpg_pkg::STEP_BITS;
    localparam int PROD_W    = COORD_BITS + STEP_W;
    // Divider: three stages, DIV_STEP quotient bits each.
    localparam int DIV_STEP  = (COORD_BITS + 2) / 3;
    localparam int DIV_BITS  = 3 * DIV_STEP;
    localparam int PER_W     = slpg_pkg::PERIOD_BITS;
    localparam int FRM_W     = slpg_pkg::FRAME_BITS;
    localparam int CMP_W     = (COORD_BITS > FRM_W) ? COORD_BITS : FRM_W;
    localparam int PIX_W     = slpg_pkg::PIX_BITS;

    typedef struct packed {
        logic [PER_W-1:0]    rem;
        logic [DIV_BITS-1:0] num;
        logic                q;
    } t_div;

    // Advance a restoring division by DIV_STEP quotient bits.
    function automatic t_div f_div_step(t_div s, logic [PER_W-1:0] d);
        t_div           o;
        logic [PER_W:0] trial;
        logic [PER_W:0] diff;
        o = s;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {o.rem, o.num[DIV_BITS-1]};
            o.num = {o.num[DIV_BITS-2:0], 1'b0};
            diff  = trial - {1'b0, d};
            if (trial >= {1'b0, d}) begin
                o.rem = diff[PER_W-1:0];
                o.q   = 1'b1;
            end else begin
                o.rem = trial[PER_W-1:0];
                o.q   = 1'b0;
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    slpg_pkg::t_mode   r_mode;
    logic [STEP_W-1:0] r_phase_step;
    logic [STEP_W-1:0] r_phase_offset;
    logic [FRM_W-1:0]  r_frame_width;
    logic [FRM_W-1:0]  r_frame_height;
    logic [PER_W-1:0]  r_col_period;
    logic [PER_W-1:0]  r_row_period;

    logic               w_cfg_wr;
    slpg_pkg::t_reg_idx w_reg_idx;

    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = slpg_pkg::t_reg_idx'(paddr[4:2]);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= slpg_pkg::MODE_VFRINGE;
            r_phase_step   <= '0;
            r_phase_offset <= '0;
            r_frame_width  <= slpg_pkg::FRAME_WIDTH_RST;
            r_frame_height <= slpg_pkg::FRAME_HEIGHT_RST;
            r_col_period   <= slpg_pkg::PERIOD_RST;
            r_row_period   <= slpg_pkg::PERIOD_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                slpg_pkg::REG_MODE: begin
                    r_mode <= slpg_pkg::t_mode'(pwdata[slpg_pkg::MODE_BITS-1:0]);
                end
                slpg_pkg::REG_PHASE_STEP: begin
                    r_phase_step <= pwdata[STEP_W-1:0];
                end
                slpg_pkg::REG_PHASE_OFFSET: begin
                    r_phase_offset <= pwdata[STEP_W-1:0];
                end
                slpg_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[FRM_W-1:0];
                end
                slpg_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[FRM_W-1:0];
                end
                slpg_pkg::REG_COL_PERIOD: begin
                    r_col_period <= pwdata[PER_W-1:0];
                end
                slpg_pkg::REG_ROW_PERIOD: begin
                    r_row_period <= pwdata[PER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            slpg_pkg::REG_MODE:         prdata = 32'(r_mode);
            slpg_pkg::REG_PHASE_STEP:   prdata = 32'(r_phase_step);
            slpg_pkg::REG_PHASE_OFFSET: prdata = 32'(r_phase_offset);
            slpg_pkg::REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            slpg_pkg::REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            slpg_pkg::REG_COL_PERIOD:   prdata = 32'(r_col_period);
            slpg_pkg::REG_ROW_PERIOD:   prdata = 32'(r_row_period);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Border limits, derived from the frame size every cycle.
    // The border width is registered first, then the limits from it; an item reaches the compare in stage 3.
    // ------------------------------------------------------------------
    logic [slpg_pkg::DIV25_PROD_BITS-1:0] w_bw_prod;
    logic [slpg_pkg::DIV25_PROD_BITS-1:0] w_bh_prod;
    logic [slpg_pkg::BORDER_BITS-1:0]     r_border_w;
    logic [slpg_pkg::BORDER_BITS-1:0]     r_border_h;
    logic [FRM_W-1:0]                     r_lim_w;
    logic [FRM_W-1:0]                     r_lim_h;

    assign w_bw_prod = slpg_pkg::DIV25_PROD_BITS'(r_frame_width)
                     * slpg_pkg::DIV25_PROD_BITS'(slpg_pkg::DIV25_MUL);
    assign w_bh_prod = slpg_pkg::DIV25_PROD_BITS'(r_frame_height)
                     * slpg_pkg::DIV25_PROD_BITS'(slpg_pkg::DIV25_MUL);

    always_ff @(posedge i_clk) begin
        r_border_w <= w_bw_prod[slpg_pkg::DIV25_SHIFT +: slpg_pkg::BORDER_BITS];
        r_border_h <= w_bh_prod[slpg_pkg::DIV25_SHIFT +: slpg_pkg::BORDER_BITS];
        r_lim_w    <= r_frame_width - FRM_W'(r_border_w);
        r_lim_h    <= r_frame_height - FRM_W'(r_border_h);
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its successor moves.
    // ------------------------------------------------------------------
    logic r1_vld, r2_vld, r3_vld, r4_vld;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4      = !r4_vld || i_out_ready;
    assign w_en3      = !r3_vld || w_en4;
    assign w_en2      = !r2_vld || w_en3;
    assign w_en1      = !r1_vld || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_vld <= i_in_valid;
            end
            if (w_en2) begin
                r2_vld <= r1_vld;
            end
            if (w_en3) begin
                r3_vld <= r2_vld;
            end
            if (w_en4) begin
                r4_vld <= r3_vld;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the fringe coordinate, multiply by the phase step,
    // first third of the checker divisions.
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0]      w_coord;
    logic [PROD_W-1:0]          w_prod;
    t_div                       w_div_x0;
    t_div                       w_div_y0;

    slpg_pkg::t_mode            r1_mode;
    logic [COORD_BITS-1:0]      r1_x;
    logic [COORD_BITS-1:0]      r1_y;
    logic [PHASE_FRAC_BITS-1:0] r1_prod;
    t_div                       r1_div_x;
    t_div                       r1_div_y;

    assign w_coord  = (r_mode == slpg_pkg::MODE_HFRINGE) ? i_pixel_y : i_pixel_x;
    assign w_prod   = PROD_W'(w_coord) * PROD_W'(r_phase_step);
    assign w_div_x0 = '{rem: '0, num: DIV_BITS'(i_pixel_x), q: 1'b0};
    assign w_div_y0 = '{rem: '0, num: DIV_BITS'(i_pixel_y), q: 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_mode  <= r_mode;
            r1_x     <= i_pixel_x;
            r1_y     <= i_pixel_y;
            r1_prod  <= w_prod[PHASE_FRAC_BITS-1:0];
            r1_div_x <= f_div_step(w_div_x0, r_col_period);
            r1_div_y <= f_div_step(w_div_y0, r_row_period);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: add the phase offset, wrap to one turn, keep the table index.
    // ------------------------------------------------------------------
    logic [PHASE_FRAC_BITS-1:0] w_phase;

    slpg_pkg::t_mode            r2_mode;
    logic [COORD_BITS-1:0]      r2_x;
    logic [COORD_BITS-1:0]      r2_y;
    logic [COS_INDEX_BITS-1:0]  r2_index;
    t_div                       r2_div_x;
    t_div                       r2_div_y;

    assign w_phase = r1_prod + PHASE_FRAC_BITS'(r_phase_offset);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_mode  <= r1_mode;
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_index <= w_phase[PHASE_FRAC_BITS-1 -: COS_INDEX_BITS];
            r2_div_x <= f_div_step(r1_div_x, r_col_period);
            r2_div_y <= f_div_step(r1_div_y, r_row_period);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cosine table read, last division step, border compare.
    // ------------------------------------------------------------------
    t_div                w_div_x3;
    t_div                w_div_y3;
    logic                w_qx;
    logic                w_qy;
    logic                w_black;
    logic [PIX_W-1:0]    w_cos;

    slpg_pkg::t_mode     r3_mode;
    logic                r3_checker;
    logic                r3_black;

    assign w_div_x3 = f_div_step(r2_div_x, r_col_period);
    assign w_div_y3 = f_div_step(r2_div_y, r_row_period);
    // a zero period counts as quotient zero
    assign w_qx     = w_div_x3.q && (r_col_period != '0);
    assign w_qy     = w_div_y3.q && (r_row_period != '0);

    assign w_black = (CMP_W'(r2_x) <  CMP_W'(r_border_w))
                  || (CMP_W'(r2_x) >= CMP_W'(r_lim_w))
                  || (CMP_W'(r2_y) <  CMP_W'(r_border_h))
                  || (CMP_W'(r2_y) >= CMP_W'(r_lim_h));

    slpg_cos_rom #(
        .INDEX_BITS (COS_INDEX_BITS)
    ) u_cos_rom (
        .i_clk   (i_clk),
        .i_en    (w_en3),
        .i_index (r2_index),
        .o_value (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_mode    <= r2_mode;
            r3_checker <= w_qx ^ w_qy;
            r3_black   <= w_black;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pattern select into the output register.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] w_value;
    logic [PIX_W-1:0] r4_value;

    always_comb begin
        case (r3_mode)
            slpg_pkg::MODE_VFRINGE,
            slpg_pkg::MODE_HFRINGE: w_value = w_cos;
            slpg_pkg::MODE_CHECKER: w_value = r3_checker ? slpg_pkg::PIX_MAX
                                                         : slpg_pkg::PIX_MIN;
            slpg_pkg::MODE_BORDER:  w_value = r3_black ? slpg_pkg::PIX_MIN
                                                       : slpg_pkg::PIX_MAX;
            default:                w_value = slpg_pkg::PIX_MIN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_value <= w_value;
        end
    end

    assign o_out_valid   = r4_vld;
    assign o_pixel_value = r4_value;

endmodule

>>> bench/tb_structured_light_pattern_pixel_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_structured_light_pattern_pixel_generator_core: self-checking bench
// Programs the pattern registers over APB (with read-back), streams pixel
// coordinates with random gaps and back-pressure, and compares every gray
// level against a bit-exact fringe/checker/border predictor.
// ----------------------------------------------------------------------------
module tb_structured_light_pattern_pixel_generator_core;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TIMEOUT_NS  = 4_000_000;
    localparam int PIPE_DEPTH  = 4;       // pipeline stages, input beat to o_out_valid
    localparam int HOLD_CYCLES = 64;      // long receiver hold-off
    localparam int IDLE_PCT    = 16;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_BEATS = 96;

    localparam int COORD_W    = 12;
    localparam int PHASE_FRAC = 24;
    localparam int COS_IDX    = 12;
    localparam int COS_N      = 1 << COS_IDX;
    localparam int BORDER_DIV = 25;

    // Q4.60 cosine arithmetic
    localparam int          QF            = 60;
    localparam logic [63:0] Q_ONE         = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60        = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] PHASE_MASK    = (64'd1 << PHASE_FRAC) - 64'd1;
    localparam int          ANGLE_SHIFT   = QF + 1 - COS_IDX;
    localparam int          TAYLOR_TERMS  = 13;
    localparam int          LEVEL_PRE_SH  = 20;
    localparam int          LEVEL_POST_SH = 41;

    // Pattern codes the package leaves unnamed; both must read as black.
    localparam logic [slpg_pkg::MODE_BITS-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [slpg_pkg::MODE_BITS-1:0] MODE_RSVD7 = 3'd7;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic [COORD_W-1:0]            i_pixel_x   = '0;
    logic [COORD_W-1:0]            i_pixel_y   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [slpg_pkg::PIX_BITS-1:0] o_pixel_value;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [4:0]                    paddr       = '0;
    logic [31:0]                   pwdata      = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    structured_light_pattern_pixel_generator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the register file, updated on every APB write
    // ------------------------------------------------------------------
    logic [slpg_pkg::MODE_BITS-1:0]   cfg_mode   = slpg_pkg::MODE_VFRINGE;
    logic [slpg_pkg::STEP_BITS-1:0]   cfg_step   = '0;
    logic [slpg_pkg::STEP_BITS-1:0]   cfg_offset = '0;
    logic [slpg_pkg::FRAME_BITS-1:0]  cfg_width  = slpg_pkg::FRAME_WIDTH_RST;
    logic [slpg_pkg::FRAME_BITS-1:0]  cfg_height = slpg_pkg::FRAME_HEIGHT_RST;
    logic [slpg_pkg::PERIOD_BITS-1:0] cfg_col    = slpg_pkg::PERIOD_RST;
    logic [slpg_pkg::PERIOD_BITS-1:0] cfg_row    = slpg_pkg::PERIOD_RST;

    // Gray levels still owed by the block, oldest first.
    logic [slpg_pkg::PIX_BITS-1:0] level_q[$];
    int unsigned                   mismatch_count = 0;

    // Traffic shaping knobs, owned by the main sequence.
    int          src_idle_pct  = IDLE_PCT;
    int          sink_idle_pct = IDLE_PCT;
    int unsigned hold_asks     = 0;

    // Directed stimulus table.
    typedef struct packed {
        logic                          is_cfg;
        slpg_pkg::t_reg_idx            idx;
        logic [31:0]                   data;
        logic [COORD_W-1:0]            x;
        logic [COORD_W-1:0]            y;
        logic                          typed;
        logic [slpg_pkg::PIX_BITS-1:0] level;
    } t_row;
    t_row dir_rows[$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // (a * b) >> 60, truncated like the 64-bit fixed-point datapath.
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[QF+63:QF];
    endfunction

    // cos(2*pi*r/N) in Q60 for r in [0, N/4]; past N/8 fold over to a sine.
    function automatic logic [63:0] cos_quarter_q60(input int unsigned idx);
        logic [63:0] ang, ang_sq, term, acc, div;
        int unsigned r;
        int          k;
        bit          use_sin;
        r = idx;
        use_sin = (r > COS_N / 8);
        if (use_sin)
            r = COS_N / 4 - r;
        ang = r;
        ang = q60_mul(PI_Q60, ang << ANGLE_SHIFT);
        ang_sq = q60_mul(ang, ang);
        term = use_sin ? ang : Q_ONE;
        acc = term;
        for (k = 1; k <= TAYLOR_TERMS; k++) begin
            div = use_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            term = q60_mul(term, ang_sq) / div;
            if (k % 2)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic [slpg_pkg::PIX_BITS-1:0] fringe_level(
        input logic [COORD_W-1:0] coord);
        longint unsigned c, phase;
        int unsigned     t, quad, r;
        logic [63:0]     mag, u, v;
        bit              neg;
        c = coord;
        phase = (c * cfg_step + cfg_offset) & PHASE_MASK;
        t = phase >> (PHASE_FRAC - COS_IDX);
        quad = t >> (COS_IDX - 2);
        r = t & (COS_N / 4 - 1);
        // reduce to the first quadrant, remember the sign
        case (quad)
            0: begin
                mag = cos_quarter_q60(r);
                neg = 1'b0;
            end
            1: begin
                mag = cos_quarter_q60(COS_N / 4 - r);
                neg = 1'b1;
            end
            2: begin
                mag = cos_quarter_q60(r);
                neg = 1'b1;
            end
            default: begin
                mag = cos_quarter_q60(COS_N / 4 - r);
                neg = 1'b0;
            end
        endcase
        if (mag > Q_ONE)
            mag = Q_ONE;
        u = neg ? Q_ONE - mag : Q_ONE + mag;
        v = ((u >> LEVEL_PRE_SH) * 64'd255) >> LEVEL_POST_SH;
        return (v > 64'd255) ? slpg_pkg::PIX_MAX : v[slpg_pkg::PIX_BITS-1:0];
    endfunction

    function automatic logic [slpg_pkg::PIX_BITS-1:0] pattern_level(
        input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int unsigned cx, cy, bw, bh, fw, fh;
        logic [slpg_pkg::PIX_BITS-1:0] lvl;
        lvl = slpg_pkg::PIX_MIN;
        case (cfg_mode)
            slpg_pkg::MODE_VFRINGE: lvl = fringe_level(x);
            slpg_pkg::MODE_HFRINGE: lvl = fringe_level(y);
            slpg_pkg::MODE_CHECKER: begin
                // a zero period collapses that axis to stripe 0
                cx = (cfg_col != 0) ? x / cfg_col : 0;
                cy = (cfg_row != 0) ? y / cfg_row : 0;
                lvl = ((cx ^ cy) & 1) ? slpg_pkg::PIX_MAX : slpg_pkg::PIX_MIN;
            end
            slpg_pkg::MODE_BORDER: begin
                fw = cfg_width;
                fh = cfg_height;
                bw = fw / BORDER_DIV;
                bh = fh / BORDER_DIV;
                if (x < bw || x >= fw - bw || y < bh || y >= fh - bh)
                    lvl = slpg_pkg::PIX_MIN;
                else
                    lvl = slpg_pkg::PIX_MAX;
            end
            default: lvl = slpg_pkg::PIX_MIN;    // black and the unused codes
        endcase
        return lvl;
    endfunction

    // ------------------------------------------------------------------
    // Bus and stream drivers (all called at a rising edge)
    // ------------------------------------------------------------------
    // Write one register, then read it back. Leaves psel high so writes can
    // run back to back; the caller drops psel after the batch.
    task automatic reg_write(input slpg_pkg::t_reg_idx idx, input logic [31:0] data);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // mirror the write, dropping bits past each register's width
        case (idx)
            slpg_pkg::REG_MODE:         cfg_mode   = data[slpg_pkg::MODE_BITS-1:0];
            slpg_pkg::REG_PHASE_STEP:   cfg_step   = data[slpg_pkg::STEP_BITS-1:0];
            slpg_pkg::REG_PHASE_OFFSET: cfg_offset = data[slpg_pkg::STEP_BITS-1:0];
            slpg_pkg::REG_FRAME_WIDTH:  cfg_width  = data[slpg_pkg::FRAME_BITS-1:0];
            slpg_pkg::REG_FRAME_HEIGHT: cfg_height = data[slpg_pkg::FRAME_BITS-1:0];
            slpg_pkg::REG_COL_PERIOD:   cfg_col    = data[slpg_pkg::PERIOD_BITS-1:0];
            default:                    cfg_row    = data[slpg_pkg::PERIOD_BITS-1:0];
        endcase
        case (idx)
            slpg_pkg::REG_MODE:         want = cfg_mode;
            slpg_pkg::REG_PHASE_STEP:   want = cfg_step;
            slpg_pkg::REG_PHASE_OFFSET: want = cfg_offset;
            slpg_pkg::REG_FRAME_WIDTH:  want = cfg_width;
            slpg_pkg::REG_FRAME_HEIGHT: want = cfg_height;
            slpg_pkg::REG_COL_PERIOD:   want = cfg_col;
            default:                    want = cfg_row;
        endcase
        // read-back: setup then access, sample in the access phase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d read-back: expected 0x%0h, actual 0x%0h", idx, want, prdata);
            mismatch_count++;
        end
    endtask

    // Offer one coordinate beat, maybe after some idle cycles, and log what
    // the block owes for it once it is accepted.
    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic typed,
                              input logic [slpg_pkg::PIX_BITS-1:0] level);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        level_q.insert(level_q.size(), typed ? level : pattern_level(x, y));
    endtask

    // Drop valid and wait until every owed gray level has come back.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Table builders and random pickers
    // ------------------------------------------------------------------
    task automatic tab_reg(input slpg_pkg::t_reg_idx idx, input logic [31:0] data);
        dir_rows.insert(dir_rows.size(),
                        t_row'{1'b1, idx, data, '0, '0, 1'b0, slpg_pkg::PIX_MIN});
    endtask

    task automatic tab_pix(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        dir_rows.insert(dir_rows.size(),
                        t_row'{1'b0, slpg_pkg::REG_MODE, 32'd0, x, y, 1'b0,
                               slpg_pkg::PIX_MIN});
    endtask

    task automatic tab_lvl(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [slpg_pkg::PIX_BITS-1:0] level);
        dir_rows.insert(dir_rows.size(),
                        t_row'{1'b0, slpg_pkg::REG_MODE, 32'd0, x, y, 1'b1, level});
    endtask

    // Fill the bits above a register's width with noise.
    function automatic logic [31:0] with_junk(input slpg_pkg::t_reg_idx idx,
                                              input logic [31:0] field);
        logic [31:0] keep;
        case (idx)
            slpg_pkg::REG_MODE:
                keep = (32'd1 << slpg_pkg::MODE_BITS) - 1;
            slpg_pkg::REG_PHASE_STEP, slpg_pkg::REG_PHASE_OFFSET:
                keep = (32'd1 << slpg_pkg::STEP_BITS) - 1;
            slpg_pkg::REG_FRAME_WIDTH, slpg_pkg::REG_FRAME_HEIGHT:
                keep = (32'd1 << slpg_pkg::FRAME_BITS) - 1;
            default:
                keep = (32'd1 << slpg_pkg::PERIOD_BITS) - 1;
        endcase
        return ($urandom() & ~keep) | (field & keep);
    endfunction

    function automatic logic [31:0] pick_phase();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFF_FFFF;
            2:       return 32'd1;
            3:       return 32'h80_0000;
            default: return $urandom_range(0, 32'hFF_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_frame();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd4096;
            3:       return 32'd8191;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd4095;
            3, 4:    return $urandom_range(1, 64);
            default: return $urandom_range(1, 4095);
        endcase
    endfunction

    // Mostly uniform, otherwise straddle one of two interesting boundaries.
    function automatic logic [COORD_W-1:0] pick_coord(input int lo_edge, input int hi_edge);
        int c;
        case ($urandom_range(0, 9))
            6, 7:    c = lo_edge + $urandom_range(0, 2) - 1;
            8, 9:    c = hi_edge + $urandom_range(0, 2) - 1;
            default: c = $urandom_range(0, (1 << COORD_W) - 1);
        endcase
        return c[COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_ready
        int unsigned seen_asks;
        int unsigned hold_left;
        seen_asks = 0;
        hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_asks != seen_asks) begin
                seen_asks = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Compare every accepted gray level against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (level_q.size() == 0) begin
                $error("pixel_value beat with nothing owed: actual %0d", o_pixel_value);
                mismatch_count++;
            end else if (o_pixel_value !== level_q[0]) begin
                $error("pixel_value mismatch: expected %0d, actual %0d",
                       level_q[0], o_pixel_value);
                mismatch_count++;
                void'(level_q.pop_front());
            end else begin
                void'(level_q.pop_front());
            end
        end
    end

    // Hard stop in case the stream wedges.
    initial begin
        #(TIMEOUT_NS);
        $display("structured_light_pattern_pixel_generator_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_row        row;
        bit          bus_owned;
        int          ph, n;
        int          ax, bx, ay, by;
        logic [31:0] mode_w;

        // Directed table. Typed levels come straight from the pattern
        // definitions; the rest go through the predictor.
        // Reset state: vertical fringe at zero phase is full white.
        tab_lvl(12'd0, 12'd0, slpg_pkg::PIX_MAX);
        tab_lvl(12'd4095, 12'd4095, slpg_pkg::PIX_MAX);
        // One cosine index per column: quarter turn is mid gray, half is black.
        tab_reg(slpg_pkg::REG_PHASE_STEP, 32'h1000);
        tab_lvl(12'd1024, 12'd7, slpg_pkg::PIX_MID);
        tab_lvl(12'd2048, 12'd0, slpg_pkg::PIX_MIN);
        tab_pix(12'd512, 12'd0);
        tab_pix(12'd4095, 12'd0);
        // Largest step and offset: phase wraps on every pixel.
        tab_reg(slpg_pkg::REG_PHASE_STEP, 32'hFF_FFFF);
        tab_reg(slpg_pkg::REG_PHASE_OFFSET, 32'hFF_FFFF);
        tab_pix(12'd4095, 12'd4095);
        // Horizontal fringe follows y and ignores x.
        tab_reg(slpg_pkg::REG_MODE, slpg_pkg::MODE_HFRINGE);
        tab_reg(slpg_pkg::REG_PHASE_STEP, 32'h1000);
        tab_reg(slpg_pkg::REG_PHASE_OFFSET, 32'd0);
        tab_lvl(12'd4095, 12'd2048, slpg_pkg::PIX_MIN);
        tab_pix(12'd0, 12'd1);
        // Checkerboard with the 64-pixel reset periods.
        tab_reg(slpg_pkg::REG_MODE, slpg_pkg::MODE_CHECKER);
        tab_lvl(12'd0, 12'd0, slpg_pkg::PIX_MIN);
        tab_lvl(12'd64, 12'd0, slpg_pkg::PIX_MAX);
        tab_lvl(12'd64, 12'd64, slpg_pkg::PIX_MIN);
        tab_lvl(12'd4095, 12'd0, slpg_pkg::PIX_MAX);
        // Zero column period pins x to stripe 0; widest row period.
        tab_reg(slpg_pkg::REG_COL_PERIOD, 32'd0);
        tab_reg(slpg_pkg::REG_ROW_PERIOD, 32'd4095);
        tab_lvl(12'd4095, 12'd4095, slpg_pkg::PIX_MAX);
        tab_lvl(12'd4095, 12'd4094, slpg_pkg::PIX_MIN);
        // Black, and an unused code that must read as black.
        tab_reg(slpg_pkg::REG_MODE, slpg_pkg::MODE_BLACK);
        tab_lvl(12'd4095, 12'd4095, slpg_pkg::PIX_MIN);
        tab_reg(slpg_pkg::REG_MODE, MODE_RSVD7);
        tab_lvl(12'd100, 12'd100, slpg_pkg::PIX_MIN);
        // Bordered white on 1024x768: 40-column, 30-row black frame.
        tab_reg(slpg_pkg::REG_MODE, slpg_pkg::MODE_BORDER);
        tab_lvl(12'd40, 12'd30, slpg_pkg::PIX_MAX);
        tab_lvl(12'd39, 12'd30, slpg_pkg::PIX_MIN);
        tab_lvl(12'd983, 12'd737, slpg_pkg::PIX_MAX);
        tab_lvl(12'd984, 12'd100, slpg_pkg::PIX_MIN);
        tab_lvl(12'd4095, 12'd4095, slpg_pkg::PIX_MIN);  // outside the frame
        // Zero-width frame is border everywhere.
        tab_reg(slpg_pkg::REG_FRAME_WIDTH, 32'd0);
        tab_lvl(12'd0, 12'd0, slpg_pkg::PIX_MIN);
        // Largest frame the register holds.
        tab_reg(slpg_pkg::REG_FRAME_WIDTH, 32'd8191);
        tab_reg(slpg_pkg::REG_FRAME_HEIGHT, 32'd8191);
        tab_pix(12'd4095, 12'd4095);
        tab_pix(12'd326, 12'd400);

        // Hold reset, then release it.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table. Drain before the first write of a group and
        // drop psel before the next coordinate beat.
        bus_owned = 1'b0;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                if (!bus_owned)
                    wait_drain();
                reg_write(row.idx, row.data);
                bus_owned = 1'b1;
            end else begin
                if (bus_owned) begin
                    psel    <= 1'b0;
                    penable <= 1'b0;
                    bus_owned = 1'b0;
                end
                send_pixel(row.x, row.y, row.typed, row.level);
            end
        end

        // Random phases: fresh register set each time, then a burst of beats.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drain();
            case (ph)
                0:       mode_w = slpg_pkg::MODE_VFRINGE;
                1:       mode_w = slpg_pkg::MODE_HFRINGE;
                2:       mode_w = slpg_pkg::MODE_CHECKER;
                3:       mode_w = slpg_pkg::MODE_BORDER;
                4:       mode_w = MODE_RSVD5;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       mode_w = slpg_pkg::MODE_VFRINGE;
                        1:       mode_w = slpg_pkg::MODE_HFRINGE;
                        2:       mode_w = slpg_pkg::MODE_CHECKER;
                        3:       mode_w = slpg_pkg::MODE_BORDER;
                        default: mode_w = $urandom_range(0, 7);
                    endcase
                end
            endcase
            reg_write(slpg_pkg::REG_MODE,
                      with_junk(slpg_pkg::REG_MODE, mode_w));
            reg_write(slpg_pkg::REG_PHASE_STEP,
                      with_junk(slpg_pkg::REG_PHASE_STEP, pick_phase()));
            reg_write(slpg_pkg::REG_PHASE_OFFSET,
                      with_junk(slpg_pkg::REG_PHASE_OFFSET, pick_phase()));
            reg_write(slpg_pkg::REG_FRAME_WIDTH,
                      with_junk(slpg_pkg::REG_FRAME_WIDTH, pick_frame()));
            reg_write(slpg_pkg::REG_FRAME_HEIGHT,
                      with_junk(slpg_pkg::REG_FRAME_HEIGHT, pick_frame()));
            reg_write(slpg_pkg::REG_COL_PERIOD,
                      with_junk(slpg_pkg::REG_COL_PERIOD, pick_period()));
            reg_write(slpg_pkg::REG_ROW_PERIOD,
                      with_junk(slpg_pkg::REG_ROW_PERIOD, pick_period()));
            psel    <= 1'b0;
            penable <= 1'b0;

            // Aim the coordinates at the edges this pattern cares about.
            if (cfg_mode == slpg_pkg::MODE_BORDER) begin
                ax = cfg_width / BORDER_DIV;
                bx = cfg_width - ax;
                ay = cfg_height / BORDER_DIV;
                by = cfg_height - ay;
            end else if (cfg_mode == slpg_pkg::MODE_CHECKER) begin
                ax = cfg_col;
                bx = 2 * cfg_col;
                ay = cfg_row;
                by = 2 * cfg_row;
            end else begin
                ax = 0;
                bx = (1 << COORD_W) - 1;
                ay = 0;
                by = (1 << COORD_W) - 1;
            end

            // One phase runs with no idling at all; another parks the
            // receiver while the sender keeps pushing, so the pipe fills
            // and o_in_ready drops.
            src_idle_pct  = (ph == 5 || ph == 8) ? 0 : IDLE_PCT;
            sink_idle_pct = (ph == 5) ? 0 : IDLE_PCT;
            if (ph == 8)
                hold_asks <= hold_asks + 1;

            for (n = 0; n < PHASE_BEATS; n++)
                send_pixel(pick_coord(ax, bx), pick_coord(ay, by), 1'b0,
                           slpg_pkg::PIX_MIN);
        end

        // Let the tail come out, then keep clocking with valid low so a
        // stray extra beat would still be caught.
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        wait_drain();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0 && level_q.size() == 0)
            $display("structured_light_pattern_pixel_generator_core verification clean");
        else
            $display("structured_light_pattern_pixel_generator_core verification failed");
        $finish;
    end

endmodule
